// ----- rtl/vcp_pkg.sv -----
// Shared types, widths and constants of the vortex core profile block.
// No dependencies; every other file of the block but vcp_ram imports this package.
package vcp_pkg;

  // Field widths
  localparam int IN_W      = 10;
  localparam int CFG_W     = 18;
  localparam int CFG_IDX_W = 3;
  localparam int LEVEL_W   = 17;
  localparam int IDX_W     = 20;
  localparam int GW_W      = 11;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_MIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_MAX  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH = 3'd5;

  // Reset values
  localparam logic [GW_W-1:0]    GRID_WIDTH  = 11'd1024;
  localparam logic [CFG_W-1:0]   RADIUS_RST  = 18'd256;
  localparam logic [LEVEL_W-1:0] ONE_Q16     = 17'd65536;

  // Distance datapath
  localparam int DIFF_W     = CFG_W + 1;      // signed dx, dy
  localparam int ABS_W      = CFG_W;          // |dx|, |dy|
  localparam int SQ_W       = 2 * ABS_W;      // dx*dx
  localparam int SUM_W      = SQ_W + 1;       // dx*dx + dy*dy
  localparam int RAD_W      = SUM_W + 1;      // radicand, even width
  localparam int ROOT_W     = RAD_W / 2;
  localparam int SQRT_REM_W = ROOT_W + 1;

  // Tanh table and lookup
  localparam int TANH_ENTRIES = 1024;
  localparam int TANH_ADDR_W  = $clog2(TANH_ENTRIES);
  localparam int FRAC_W       = 9;
  localparam int U_W          = TANH_ADDR_W + FRAC_W;   // unsaturated quotient bits
  localparam int U_SHIFT      = U_W - 16;               // r<<16 vs radius<<U_W
  localparam int PROD_W       = LEVEL_W + FRAC_W;
  localparam int BLEND_W      = 2 * LEVEL_W;

  // Table build recurrence, Q30
  localparam int T_W        = 31;
  localparam int STEP_W     = 24;
  localparam logic [STEP_W-1:0] TANH_STEP_Q30 = 24'd8388437;
  localparam int TPROD_W    = T_W + STEP_W;
  localparam int DVD_W      = T_W + 30;
  localparam int DVS_W      = 31;
  localparam int DCNT_W     = $clog2(DVD_W);

  typedef logic [IDX_W-1:0] idx_t;

endpackage

// ----- rtl/vortex_core_profile.sv -----
// Top level of the vortex core profile generator: config registers, distance,
// divider and blend pipeline. Uses vcp_pkg, vcp_sqrt_pipe, vcp_tanh_table.
//
// Usage:
//   Input words enter on start while busy is low (pixel_x, pixel_y).
//   One result word per input leaves on done for a single cycle, carrying
//   level and pixel_index; the receiver takes it in that cycle.
//   A new word can enter every cycle once busy is low; the pipeline never
//   stalls, so throughput is one word per clock, set by the bit-per-stage
//   root and divider pipelines (19 stages each).
//   Configuration: cfg_write, cfg_index, cfg_data write one register per
//   cycle, with no wait; write only while no word is in flight.
//   Reset (rst, synchronous): registers take their reset values and the
//   tanh table is rebuilt by a serial divider, one entry after another,
//   during which busy is high and start is ignored.
//   Config writes are taken during that time.
module vortex_core_profile
  import vcp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [IN_W-1:0]      pixel_x,
  input  logic [IN_W-1:0]      pixel_y,
  output logic                 done,
  output logic [LEVEL_W-1:0]   level,
  output logic [IDX_W-1:0]     pixel_index,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // Configuration registers
  logic [CFG_W-1:0]   centre_x;
  logic [CFG_W-1:0]   centre_y;
  logic [CFG_W-1:0]   radius;
  logic [LEVEL_W-1:0] level_min;
  logic [LEVEL_W-1:0] level_max;
  logic [GW_W-1:0]    grid_width;
  logic [CFG_W-1:0]   rad_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      centre_x   <= '0;
      centre_y   <= '0;
      radius     <= RADIUS_RST;
      level_min  <= '0;
      level_max  <= ONE_Q16;
      grid_width <= GRID_WIDTH;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CENTRE_X:   centre_x   <= cfg_data;
        REG_CENTRE_Y:   centre_y   <= cfg_data;
        REG_RADIUS:     radius     <= cfg_data;
        REG_LEVEL_MIN:  level_min  <= cfg_data[LEVEL_W-1:0];
        REG_LEVEL_MAX:  level_max  <= cfg_data[LEVEL_W-1:0];
        REG_GRID_WIDTH: grid_width <= cfg_data[GW_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero radius acts as the smallest step
  assign rad_eff = (radius == '0) ? CFG_W'(1) : radius;

  logic table_ready;
  logic accept;
  assign busy   = !table_ready;
  assign accept = start && table_ready;

  // Stage A: signed offsets and their magnitudes
  logic [DIFF_W-1:0] dx_full, dy_full, dx_neg, dy_neg;
  assign dx_full = {1'b0, pixel_x, 8'd0} - {1'b0, centre_x};
  assign dy_full = {1'b0, pixel_y, 8'd0} - {1'b0, centre_y};
  assign dx_neg  = ~dx_full + DIFF_W'(1);
  assign dy_neg  = ~dy_full + DIFF_W'(1);

  logic              a_vld;
  logic [ABS_W-1:0]  a_adx, a_ady;
  logic [IN_W-1:0]   a_px, a_py;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= accept;
    end
    a_adx <= dx_full[DIFF_W-1] ? dx_neg[ABS_W-1:0] : dx_full[ABS_W-1:0];
    a_ady <= dy_full[DIFF_W-1] ? dy_neg[ABS_W-1:0] : dy_full[ABS_W-1:0];
    a_px  <= pixel_x;
    a_py  <= pixel_y;
  end

  // Stage B: squares and the linear index
  logic [IN_W+GW_W-1:0] idx_prod, idx_sum;
  assign idx_prod = a_py * grid_width;
  assign idx_sum  = idx_prod + (IN_W+GW_W)'(a_px);

  logic            b_vld;
  logic [SQ_W-1:0] b_sqx, b_sqy;
  idx_t            b_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else begin
      b_vld <= a_vld;
    end
    b_sqx <= a_adx * a_adx;
    b_sqy <= a_ady * a_ady;
    b_idx <= idx_sum[IDX_W-1:0];
  end

  // Stage C: squared distance
  logic             c_vld;
  logic [SUM_W-1:0] c_s;
  idx_t             c_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else begin
      c_vld <= b_vld;
    end
    c_s   <= {1'b0, b_sqx} + {1'b0, b_sqy};
    c_idx <= b_idx;
  end

  // Root pipeline
  logic              r_vld;
  logic [ROOT_W-1:0] r_root;
  idx_t              r_idx;

  vcp_sqrt_pipe u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (c_vld),
    .in_value  ({1'b0, c_s}),
    .in_tag    (c_idx),
    .out_valid (r_vld),
    .out_root  (r_root),
    .out_tag   (r_idx)
  );

  // Divider setup: saturation test and the leading partial remainder
  logic [CFG_W+U_SHIFT-1:0] rad_scaled;
  assign rad_scaled = {rad_eff, U_SHIFT'(0)};

  logic             d_vld;
  logic             d_sat;
  logic [CFG_W-1:0] d_rem;
  logic [U_W-1:0]   d_nb;
  idx_t             d_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else begin
      d_vld <= r_vld;
    end
    d_sat <= (CFG_W+U_SHIFT)'(r_root) >= rad_scaled;
    d_rem <= CFG_W'(r_root >> U_SHIFT);
    d_nb  <= {r_root[U_SHIFT-1:0], 16'd0};
    d_idx <= r_idx;
  end

  // Divider pipeline, one quotient bit per stage
  logic             dv_vld [U_W];
  logic             dv_sat [U_W];
  logic [CFG_W-1:0] dv_rem [U_W];
  logic [U_W-1:0]   dv_q   [U_W];
  logic [U_W-1:0]   dv_nb  [U_W];
  idx_t             dv_idx [U_W];

  for (genvar j = 0; j < U_W; j++) begin : g_div
    logic             p_vld;
    logic             p_sat;
    logic [CFG_W-1:0] p_rem;
    logic [U_W-1:0]   p_q;
    logic [U_W-1:0]   p_nb;
    idx_t             p_idx;
    logic [CFG_W:0]   rem_sh;
    logic [CFG_W:0]   rem_diff;
    logic             ge;

    if (j == 0) begin : g_first
      assign p_vld = d_vld;
      assign p_sat = d_sat;
      assign p_rem = d_rem;
      assign p_q   = '0;
      assign p_nb  = d_nb;
      assign p_idx = d_idx;
    end else begin : g_rest
      assign p_vld = dv_vld[j-1];
      assign p_sat = dv_sat[j-1];
      assign p_rem = dv_rem[j-1];
      assign p_q   = dv_q[j-1];
      assign p_nb  = dv_nb[j-1];
      assign p_idx = dv_idx[j-1];
    end

    assign rem_sh   = {p_rem, p_nb[U_W-1]};
    assign ge       = rem_sh >= {1'b0, rad_eff};
    assign rem_diff = rem_sh - {1'b0, rad_eff};

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[j] <= 1'b0;
      end else begin
        dv_vld[j] <= p_vld;
      end
      dv_sat[j] <= p_sat;
      dv_rem[j] <= ge ? rem_diff[CFG_W-1:0] : rem_sh[CFG_W-1:0];
      dv_q[j]   <= {p_q[U_W-2:0], ge};
      dv_nb[j]  <= {p_nb[U_W-2:0], 1'b0};
      dv_idx[j] <= p_idx;
    end
  end

  // Table read: entry i and i+1, fraction carried alongside
  logic [TANH_ADDR_W-1:0] tab_addr;
  logic [LEVEL_W-1:0]     tab_lo, tab_hi;
  assign tab_addr = dv_q[U_W-1][U_W-1:FRAC_W];

  vcp_tanh_table u_table (
    .clk     (clk),
    .rst     (rst),
    .ready   (table_ready),
    .rd_addr (tab_addr),
    .rd_lo   (tab_lo),
    .rd_hi   (tab_hi)
  );

  logic              t_vld;
  logic              t_sat;
  logic              t_last;
  logic [FRAC_W-1:0] t_f;
  idx_t              t_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      t_vld <= 1'b0;
    end else begin
      t_vld <= dv_vld[U_W-1];
    end
    t_sat  <= dv_sat[U_W-1];
    t_last <= (tab_addr == TANH_ADDR_W'(TANH_ENTRIES - 1));
    t_f    <= dv_q[U_W-1][FRAC_W-1:0];
    t_idx  <= dv_idx[U_W-1];
  end

  // Interpolation product
  logic [LEVEL_W-1:0] hi_end, hi_eff, span;
  assign hi_end = t_last ? ONE_Q16 : tab_hi;
  assign hi_eff = (hi_end < tab_lo) ? tab_lo : hi_end;
  assign span   = hi_eff - tab_lo;

  logic               p_vld;
  logic               p_sat;
  logic [LEVEL_W-1:0] p_lo;
  logic [PROD_W-1:0]  p_prod;
  idx_t               p_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else begin
      p_vld <= t_vld;
    end
    p_sat  <= t_sat;
    p_lo   <= tab_lo;
    p_prod <= span * t_f;
    p_idx  <= t_idx;
  end

  // Tanh value
  logic               h_vld;
  logic [LEVEL_W-1:0] h_th;
  idx_t               h_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_vld <= 1'b0;
    end else begin
      h_vld <= p_vld;
    end
    h_th  <= p_sat ? ONE_Q16 : (p_lo + p_prod[PROD_W-1:FRAC_W]);
    h_idx <= p_idx;
  end

  // Blend products
  logic               m_vld;
  logic [BLEND_W-1:0] m_lo, m_hi;
  idx_t               m_idx;
  logic [LEVEL_W-1:0] th_inv;
  assign th_inv = ONE_Q16 - h_th;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else begin
      m_vld <= h_vld;
    end
    m_lo  <= level_min * th_inv;
    m_hi  <= level_max * h_th;
    m_idx <= h_idx;
  end

  // Rounded sum and output word
  logic [BLEND_W:0] blend_sum;
  assign blend_sum = {1'b0, m_lo} + {1'b0, m_hi} + (BLEND_W+1)'(32768);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= m_vld;
    end
    level       <= blend_sum[LEVEL_W+15:16];
    pixel_index <= m_idx;
  end

endmodule

// ----- rtl/vcp_ram.sv -----
// Generic simple dual-read RAM: one write port, two registered read ports.
// No dependencies.
module vcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- rtl/vcp_tanh_table.sv -----
// Tanh table: builds entries after reset by an integer recurrence with a
// bit-serial divider, then serves two registered reads. Uses vcp_pkg, vcp_ram.
module vcp_tanh_table
  import vcp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  output logic                   ready,
  input  logic [TANH_ADDR_W-1:0] rd_addr,
  output logic [LEVEL_W-1:0]     rd_lo,
  output logic [LEVEL_W-1:0]     rd_hi
);

  localparam logic [1:0] ST_WRITE = 2'd0;
  localparam logic [1:0] ST_MUL   = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]             state;
  logic                   load;
  logic [TANH_ADDR_W-1:0] k;
  logic [T_W-1:0]         t;
  logic [TPROD_W-1:0]     tprod;
  logic [DVS_W-1:0]       dvs;
  logic [DVD_W-1:0]       dvd;
  logic [DVS_W-1:0]       rem;
  logic [T_W-1:0]         quo;
  logic [DCNT_W-1:0]      cnt;

  logic                   we;
  logic [T_W:0]           t_round;
  logic [DVS_W:0]         rem_sh;
  logic                   ge;
  logic [DVS_W:0]         rem_diff;
  logic [T_W-1:0]         quo_next;
  logic [T_W-1:0]         t_plus;
  logic [TANH_ADDR_W-1:0] rd_addr_hi;

  // Entry k = round(t / 2^14)
  assign t_round  = {1'b0, t} + (T_W+1)'(8192);
  assign we       = (state == ST_WRITE);

  // One restoring division step
  assign rem_sh   = {rem, dvd[DVD_W-1]};
  assign ge       = rem_sh >= {1'b0, dvs};
  assign rem_diff = rem_sh - {1'b0, dvs};
  assign quo_next = {quo[T_W-2:0], ge};
  assign t_plus   = t + T_W'(TANH_STEP_Q30);

  // Build sequencer: write entry, multiply, divide for the next term
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_WRITE;
      load  <= 1'b0;
      k     <= '0;
      t     <= '0;
      cnt   <= '0;
    end else begin
      unique case (state)
        ST_WRITE: begin
          if (k == TANH_ADDR_W'(TANH_ENTRIES - 1)) begin
            state <= ST_DONE;
          end else begin
            state <= ST_MUL;
            load  <= 1'b0;
          end
        end
        ST_MUL: begin
          if (!load) begin
            tprod <= t * T_W'(TANH_STEP_Q30);
            load  <= 1'b1;
          end else begin
            dvs   <= DVS_W'(1 << 30) + DVS_W'(tprod[TPROD_W-1:30]);
            dvd   <= {t_plus, 30'd0};
            rem   <= '0;
            quo   <= '0;
            cnt   <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem <= ge ? rem_diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
          quo <= quo_next;
          dvd <= {dvd[DVD_W-2:0], 1'b0};
          cnt <= cnt + DCNT_W'(1);
          if (cnt == DCNT_W'(DVD_W - 1)) begin
            t     <= quo_next;
            k     <= k + TANH_ADDR_W'(1);
            state <= ST_WRITE;
          end
        end
        ST_DONE: begin
          state <= ST_DONE;
        end
        default: state <= ST_DONE;
      endcase
    end
  end

  assign ready      = (state == ST_DONE);
  assign rd_addr_hi = rd_addr + TANH_ADDR_W'(1);

  vcp_ram #(
    .WIDTH (LEVEL_W),
    .DEPTH (TANH_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (k),
    .wdata   (t_round[LEVEL_W+13:14]),
    .raddr_a (rd_addr),
    .rdata_a (rd_lo),
    .raddr_b (rd_addr_hi),
    .rdata_b (rd_hi)
  );

endmodule

// ----- rtl/vcp_sqrt_pipe.sv -----
// Pipelined integer square root, one root bit per stage, with a pass-along tag.
// Uses vcp_pkg.
module vcp_sqrt_pipe
  import vcp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [RAD_W-1:0]  in_value,
  input  idx_t              in_tag,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output idx_t              out_tag
);

  logic                  vld  [ROOT_W];
  logic [SQRT_REM_W-1:0] rem  [ROOT_W];
  logic [ROOT_W-1:0]     root [ROOT_W];
  logic [RAD_W-1:0]      rad  [ROOT_W];
  idx_t                  tag  [ROOT_W];

  for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
    logic                  p_vld;
    logic [SQRT_REM_W-1:0] p_rem;
    logic [ROOT_W-1:0]     p_root;
    logic [RAD_W-1:0]      p_rad;
    idx_t                  p_tag;
    logic [SQRT_REM_W+1:0] rem_sh;
    logic [SQRT_REM_W+1:0] trial;
    logic [SQRT_REM_W+1:0] rem_diff;
    logic                  ge;

    if (j == 0) begin : g_first
      assign p_vld  = in_valid;
      assign p_rem  = '0;
      assign p_root = '0;
      assign p_rad  = in_value;
      assign p_tag  = in_tag;
    end else begin : g_rest
      assign p_vld  = vld[j-1];
      assign p_rem  = rem[j-1];
      assign p_root = root[j-1];
      assign p_rad  = rad[j-1];
      assign p_tag  = tag[j-1];
    end

    // Bring down the next two radicand bits, try root*4+1
    assign rem_sh   = {p_rem, p_rad[RAD_W-1 -: 2]};
    assign trial    = {1'b0, p_root, 2'b01};
    assign ge       = rem_sh >= trial;
    assign rem_diff = rem_sh - trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else begin
        vld[j] <= p_vld;
      end
      rem[j]  <= ge ? rem_diff[SQRT_REM_W-1:0] : rem_sh[SQRT_REM_W-1:0];
      root[j] <= {p_root[ROOT_W-2:0], ge};
      rad[j]  <= {p_rad[RAD_W-3:0], 2'b00};
      tag[j]  <= p_tag;
    end
  end

  assign out_valid = vld[ROOT_W-1];
  assign out_root  = root[ROOT_W-1];
  assign out_tag   = tag[ROOT_W-1];

endmodule

// ----- test/vortex_core_profile_tb.sv -----
// Self-checking testbench of vortex_core_profile: directed and random pixel words
// are checked against an in-bench fixed-point predictor. Depends on vcp_pkg and vortex_core_profile.
`timescale 1ns / 1ps

module vortex_core_profile_tb;
  import vcp_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int DRAIN_CYCLES = 60;
  localparam int TABLE_N = 1024;
  localparam longint unsigned STEP_Q30 = 64'd8388437;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic [IN_W-1:0]      pixel_x = '0;
  logic [IN_W-1:0]      pixel_y = '0;
  logic                 done;
  logic [LEVEL_W-1:0]   level;
  logic [IDX_W-1:0]     pixel_index;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Shadow copy of the registers
  logic [17:0] sh_cx, sh_cy, sh_rad;
  logic [16:0] sh_lmin, sh_lmax;
  logic [10:0] sh_gw;

  int unsigned tanh_q16 [TABLE_N];
  logic [LEVEL_W-1:0] level_q[$];
  logic [IDX_W-1:0]   index_q[$];
  int errors = 0;
  int cycles = 0;
  int idle_pct = 0;

  vortex_core_profile dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .pixel_x(pixel_x), .pixel_y(pixel_y), .done(done), .level(level),
    .pixel_index(pixel_index), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
  endtask

  // Tanh table from the Q30 recurrence
  task automatic build_tanh();
    longint unsigned t;
    t = 0;
    for (int k = 0; k < TABLE_N; k++) begin
      tanh_q16[k] = int'((t + 64'd8192) >> 14);
      t = ((t + STEP_Q30) << 30) / ((64'd1 << 30) + ((t * STEP_Q30) >> 30));
    end
  endtask

  function automatic longint unsigned floor_root(input longint unsigned s);
    longint unsigned res, cand;
    res = 0;
    for (int b = 21; b >= 0; b--) begin
      cand = res | (64'd1 << b);
      if (cand * cand <= s) res = cand;
    end
    return res;
  endfunction

  // Expected profile level of one pixel
  function automatic logic [LEVEL_W-1:0] profile_level(input logic [9:0] px,
                                                       input logic [9:0] py);
    longint signed dx, dy;
    longint unsigned s, r, u, rad, idx, fr, lo, hi, th, lv;
    dx = longint'(px) * 256 - longint'(sh_cx);
    dy = longint'(py) * 256 - longint'(sh_cy);
    s = longint'(dx * dx) + longint'(dy * dy);
    r = floor_root(s);
    rad = (sh_rad == 0) ? 1 : sh_rad;
    u = (r << 16) / rad;
    if (u > TABLE_N * 512) u = TABLE_N * 512;
    idx = u >> 9;
    fr = u & 511;
    if (idx >= TABLE_N) th = 65536;
    else begin
      lo = tanh_q16[idx];
      hi = (idx + 1 < TABLE_N) ? tanh_q16[idx + 1] : 65536;
      if (hi < lo) hi = lo;
      th = lo + (((hi - lo) * fr) >> 9);
    end
    lv = (longint'(sh_lmin) * (65536 - th) + longint'(sh_lmax) * th + 32768) >> 16;
    return lv[LEVEL_W-1:0];
  endfunction

  // Result checker
  always @(posedge clk) begin
    if (!rst && done) begin
      if (level_q.size() == 0) begin
        errors++;
        $display("unexpected result word at cycle %0d", cycles);
      end else begin
        if (level !== level_q[0]) report("level", level, level_q[0]);
        if (pixel_index !== index_q[0]) report("pixel_index", pixel_index, index_q[0]);
        void'(level_q.pop_front());
        void'(index_q.pop_front());
      end
    end
  end

  // Send one pixel word; the expectation is queued at the accepting edge
  task automatic send_pixel(input logic [9:0] px, input logic [9:0] py);
    logic [19:0] lin;
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    pixel_x = px;
    pixel_y = py;
    while (busy) @(negedge clk);
    @(posedge clk);
    lin = 20'(py * sh_gw + px);
    level_q.push_back(profile_level(px, py));
    index_q.push_back(lin);
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic wait_idle();
    while (level_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] ri, input logic [17:0] val);
    cfg_write = 1'b1;
    cfg_index = ri;
    cfg_data = val;
    @(negedge clk);
    cfg_write = 1'b0;
    case (ri)
      REG_CENTRE_X:   sh_cx = val;
      REG_CENTRE_Y:   sh_cy = val;
      REG_RADIUS:     sh_rad = val;
      REG_LEVEL_MIN:  sh_lmin = val[16:0];
      REG_LEVEL_MAX:  sh_lmax = val[16:0];
      REG_GRID_WIDTH: sh_gw = val[10:0];
      default: ;
    endcase
  endtask

  task automatic set_all(input logic [17:0] cx, cy, rad, lmin, lmax, gw);
    wait_idle();
    write_reg(REG_CENTRE_X, cx);
    write_reg(REG_CENTRE_Y, cy);
    write_reg(REG_RADIUS, rad);
    write_reg(REG_LEVEL_MIN, lmin);
    write_reg(REG_LEVEL_MAX, lmax);
    write_reg(REG_GRID_WIDTH, gw);
  endtask

  // Defaults after reset: corners, centre and pixels near the core
  task automatic test_defaults();
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd1, 10'd0);
    send_pixel(10'd0, 10'd3);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd0, 10'd1023);
  endtask

  // Register extremes and the open cases
  task automatic test_extremes();
    // zero radius, wide levels, centre at the far corner
    set_all(18'h3FFFF, 18'h3FFFF, 18'd0, 18'h1FFFF, 18'd0, 11'd2047);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd1023, 10'd1022);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    // huge radius, falling blend, narrow grid with out-of-row pixels
    set_all(18'd128, 18'd77, 18'h3FFFF, 18'd65536, 18'd0, 18'd1);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd512, 10'd300);
    // grid width zero and unknown register indexes ignored
    set_all(18'd40000, 18'd200000, 18'd1, 18'd1, 18'h1FFFF, 18'd0);
    write_reg(3'd6, 18'h3FFFF);
    write_reg(3'd7, 18'h15555);
    send_pixel(10'd156, 10'd781);
    send_pixel(10'd157, 10'd781);
    send_pixel(10'd1023, 10'd0);
    // index wrap and interpolation near the end of the table
    set_all(18'd0, 18'd0, 18'd2048, 18'd100, 18'd65536, 18'd2047);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd63, 10'd0);
    send_pixel(10'd64, 10'd0);
    send_pixel(10'd8, 10'd8);
    send_pixel(10'h2AA, 10'h155);
    send_pixel(10'h155, 10'h2AA);
  endtask

  // Random phase: random registers, pixels mostly near the core
  task automatic test_random(input int n, input int pct);
    logic [9:0] cxp, cyp;
    logic [17:0] rad;
    int k;
    idle_pct = pct;
    k = 0;
    while (k < n) begin
      cxp = 10'($urandom_range(1023));
      cyp = 10'($urandom_range(1023));
      case ($urandom_range(3))
        0: rad = 18'($urandom_range(8));
        1: rad = 18'($urandom_range(4096, 1));
        2: rad = 18'($urandom_range(65536, 256));
        default: rad = 18'($urandom);
      endcase
      set_all({cxp, 8'($urandom)}, {cyp, 8'($urandom)}, rad,
              ($urandom_range(3) == 0) ? 18'($urandom) : 18'($urandom_range(65536)),
              ($urandom_range(3) == 0) ? 18'($urandom) : 18'($urandom_range(65536)),
              ($urandom_range(4) == 0) ? 18'($urandom) : 18'($urandom_range(1024, 1)));
      for (int j = 0; j < 50 && k < n; j++, k++) begin
        if ($urandom_range(3) == 0)
          send_pixel(10'($urandom), 10'($urandom));
        else
          send_pixel(10'(cxp + $urandom_range(40) - 20), 10'(cyp + $urandom_range(40) - 20));
      end
    end
  endtask

  initial begin
    build_tanh();
    sh_cx = '0;
    sh_cy = '0;
    sh_rad = 18'd256;
    sh_lmin = '0;
    sh_lmax = 17'd65536;
    sh_gw = 11'd1024;
    repeat (5) @(negedge clk);
    rst = 1'b0;
    test_defaults();
    test_extremes();
    test_random(400, 0);
    test_random(400, 76);
    test_random(350, 0);
    test_random(350, 38);
    wait_idle();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
